// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define SIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sis_pkg.sv =====
`default_nettype none

package sis_pkg;

    localparam int DEPTH_DEF         = 64;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 16;

    // order_mode register
    localparam int MODE_W          = 2;
    localparam int MODE_SIGNED_BIT = 0;
    localparam int MODE_DESC_BIT   = 1;

    typedef struct packed {
        logic load_in;
        logic mark_drop;
        logic ins_rd;
        logic ins_step;
        logic ins_final;
        logic emit_rd;
        logic emit_ld;
        logic idx_clr;
    } sis_cmd_t;

    typedef struct packed {
        logic full;
        logic idx_at_cnt;
        logic last_pending;
        logic emit_last;
        logic out_free;
    } sis_status_t;

endpackage

`default_nettype wire

// ===== sv/sis_ram.sv =====
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/sis_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module sis_ctrl
    import sis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    input  wire sis_status_t status,
    output sis_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_CMP  = 5'b00100,
        S_ERD  = 5'b01000,
        S_ELD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.full)
                    begin
                        // store full: drop the item, still flush if it closes the set
                        cmd.mark_drop = 1'b1;
                        if (in_last)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_ERD;
                        end
                    end
                    else
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = S_INS;
                    end
                end
            end
            S_INS:
            begin
                if (status.idx_at_cnt)
                begin
                    cmd.ins_final = 1'b1;
                    if (status.last_pending)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_ERD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.ins_step = 1'b1;
                state_next   = S_INS;
            end
            S_ERD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_ELD;
            end
            S_ELD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = status.emit_last ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SIS_ASSERT_NEXT(a_accept_to_insert, in_valid && in_ready && !status.full,
        state_reg == S_INS, "accepted item did not start insertion")
    `SIS_ASSERT(a_load_slot_free, !cmd.emit_ld || status.out_free,
        "result loaded over an untaken result")

endmodule

`default_nettype wire

// ===== sv/sis_dpath.sv =====
`default_nettype none
`include "assert_macros.svh"

module sis_dpath
    import sis_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write_en,
    input  wire logic [MODE_W-1:0]        cfg_write_data,
    input  wire logic [KEY_WIDTH-1:0]     key,
    input  wire logic [PAYLOAD_WIDTH-1:0] payload,
    input  wire logic                     last_item,
    input  wire sis_cmd_t                 cmd,
    output sis_status_t                   status,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [KEY_WIDTH-1:0]          sorted_key,
    output logic [PAYLOAD_WIDTH-1:0]      sorted_payload,
    output logic                          last_result,
    output logic                          overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    logic [MODE_W-1:0]        mode_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            idx_reg;
    logic                     drop_reg;
    logic                     found_reg;
    logic                     last_reg;
    logic [KEY_WIDTH-1:0]     new_key_reg;
    logic [EW-1:0]            hold_reg;
    logic                     out_valid_reg;
    logic [KEY_WIDTH-1:0]     out_key_reg;
    logic [PAYLOAD_WIDTH-1:0] out_pay_reg;
    logic                     out_last_reg;
    logic                     out_ovf_reg;

    logic [EW-1:0]            rd_data;
    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic [KEY_WIDTH-1:0]     sign_flip;
    logic [KEY_WIDTH-1:0]     cmp_a;
    logic [KEY_WIDTH-1:0]     cmp_b;
    logic                     sorts_before;
    logic                     wr_en;
    logic                     rd_en;
    logic                     shift_now;

    assign rd_key = rd_data[EW-1 -: KEY_WIDTH];
    assign rd_pay = rd_data[PAYLOAD_WIDTH-1:0];

    // signed order is unsigned order with the sign bit inverted
    assign sign_flip = mode_reg[MODE_SIGNED_BIT] ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
    assign cmp_a     = new_key_reg ^ sign_flip;
    assign cmp_b     = rd_key ^ sign_flip;
    assign sorts_before = mode_reg[MODE_DESC_BIT] ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    // once the slot is found every later entry moves up by one
    assign shift_now = cmd.ins_step && (found_reg || sorts_before);
    assign wr_en     = cmd.ins_final || shift_now;
    assign rd_en     = cmd.ins_rd || cmd.emit_rd;

    sis_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (hold_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end

            if (cmd.load_in)
            begin
                found_reg <= 1'b0;
                last_reg  <= last_item;
            end
            else if (shift_now)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.load_in || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.ins_step || cmd.emit_ld)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            if (cmd.ins_final)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.emit_ld && status.emit_last)
            begin
                cnt_reg <= '0;
            end

            if (cmd.mark_drop)
            begin
                drop_reg <= 1'b1;
            end
            else if (cmd.emit_ld && status.emit_last)
            begin
                drop_reg <= 1'b0;
            end

            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            new_key_reg <= key;
            hold_reg    <= {key, payload};
        end
        else if (shift_now)
        begin
            hold_reg <= rd_data;
        end

        if (cmd.emit_ld)
        begin
            out_key_reg  <= rd_key;
            out_pay_reg  <= rd_pay;
            out_last_reg <= status.emit_last;
            out_ovf_reg  <= drop_reg;
        end
    end

    assign status.full         = (cnt_reg == CW'(DEPTH));
    assign status.idx_at_cnt   = (idx_reg == cnt_reg);
    assign status.last_pending = last_reg;
    assign status.emit_last    = (idx_reg == cnt_reg - CW'(1));
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign sorted_key     = out_key_reg;
    assign sorted_payload = out_pay_reg;
    assign last_result    = out_last_reg;
    assign overflow       = out_ovf_reg;

    `SIS_ASSERT(a_no_insert_when_full, !cmd.ins_final || !status.full,
        "insertion into a full store")
    `SIS_ASSERT(a_emit_not_empty, !cmd.emit_rd || (cnt_reg != '0),
        "emission started on an empty store")
    `SIS_ASSERT_NEXT(a_set_cleared, cmd.emit_ld && status.emit_last,
        (cnt_reg == '0) && !drop_reg, "store not cleared after the final result")

endmodule

`default_nettype wire

// ===== sv/stable_insertion_sorter.sv =====
`default_nettype none

// Stable insertion sorter. Each input item carries one element (key and payload); it is
// placed after every stored element that does not sort strictly after it, so equal keys
// keep arrival order. The item flagged last_item triggers one result item per stored
// element in sorted order, last_result on the final one and overflow on all of them if
// the set lost elements to a full store; the store is then empty for the next set.
// order_mode: 0 unsigned ascending, 1 signed ascending, 2 unsigned descending,
// 3 signed descending; write it only between items. An insertion walks the element memory,
// reading each stored entry in turn and writing back each one that is shifted up, and
// in_ready stays low until the walk ends; an element dropped on a full store is taken
// without a walk. Emission reads one result at a time from the memory and loads it only
// once out_ready has taken the previous one, and the block takes a new item as soon as
// the final result is in the output register.
module stable_insertion_sorter
    import sis_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write_en,
    input  wire logic [MODE_W-1:0]        cfg_write_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [KEY_WIDTH-1:0]     key,
    input  wire logic [PAYLOAD_WIDTH-1:0] payload,
    input  wire logic                     last_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [KEY_WIDTH-1:0]          sorted_key,
    output logic [PAYLOAD_WIDTH-1:0]      sorted_payload,
    output logic                          last_result,
    output logic                          overflow
);

    sis_cmd_t    cmd;
    sis_status_t status;

    sis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_item),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sis_dpath #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .key            (key),
        .payload        (payload),
        .last_item      (last_item),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .last_result    (last_result),
        .overflow       (overflow)
    );

endmodule

`default_nettype wire

// ===== tb/sv/stable_insertion_sorter_checker.sv =====
module stable_insertion_sorter_checker
    import sis_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [MODE_W-1:0]            cfg_write_data,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [KEY_WIDTH_DEF-1:0]     key,
    input  wire logic [PAYLOAD_WIDTH_DEF-1:0] payload,
    input  wire logic                         last_item,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [KEY_WIDTH_DEF-1:0]     sorted_key,
    input  wire logic [PAYLOAD_WIDTH_DEF-1:0] sorted_payload,
    input  wire logic                         last_result,
    input  wire logic                         overflow,
    output int unsigned                       mismatches,
    output int unsigned                       awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KEY_WIDTH_DEF-1:0]     key_v;
        logic [PAYLOAD_WIDTH_DEF-1:0] pay_v;
        logic                         last_v;
        logic                         ovf_v;
    } sorted_elem_t;

    // model of the element store, kept in sorted order
    logic [KEY_WIDTH_DEF-1:0]     held_key [DEPTH_DEF];
    logic [PAYLOAD_WIDTH_DEF-1:0] held_pay [DEPTH_DEF];
    int unsigned                  held_count;
    logic                         held_dropped;
    logic [MODE_W-1:0]            order_mode;
    sorted_elem_t                 pending_sorted [$];

    initial begin
        mismatches = 0;
        awaiting   = 0;
    end

    // a must go strictly ahead of b under the given order
    function automatic bit sorts_ahead(input logic [KEY_WIDTH_DEF-1:0] a,
                                       input logic [KEY_WIDTH_DEF-1:0] b,
                                       input logic [MODE_W-1:0] m);
        if (m[MODE_SIGNED_BIT])
            return m[MODE_DESC_BIT] ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
        return m[MODE_DESC_BIT] ? (a > b) : (a < b);
    endfunction

    task automatic take_element(input logic [KEY_WIDTH_DEF-1:0] k,
                                input logic [PAYLOAD_WIDTH_DEF-1:0] p,
                                input logic is_last);
        int unsigned  slot;
        bit           placed;
        sorted_elem_t r;
        if (held_count < DEPTH_DEF) begin
            slot   = held_count;
            placed = 1'b0;
            for (int unsigned i = 0; i < held_count; i++) begin
                if (!placed && sorts_ahead(k, held_key[i], order_mode)) begin
                    slot   = i;
                    placed = 1'b1;
                end
            end
            for (int unsigned i = held_count; i > slot; i--) begin
                held_key[i] = held_key[i-1];
                held_pay[i] = held_pay[i-1];
            end
            held_key[slot] = k;
            held_pay[slot] = p;
            held_count++;
        end
        else begin
            held_dropped = 1'b1;
        end
        if (is_last) begin
            for (int unsigned i = 0; i < held_count; i++) begin
                r.key_v  = held_key[i];
                r.pay_v  = held_pay[i];
                r.last_v = (i + 1 == held_count);
                r.ovf_v  = held_dropped;
                pending_sorted.push_back(r);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        sorted_elem_t want;
        if (pending_sorted.size() == 0) begin
            $display("%0t: result key %h payload %h arrived with nothing expected",
                     $time, sorted_key, sorted_payload);
            mismatches++;
        end
        else begin
            want = pending_sorted.pop_front();
            if (sorted_key !== want.key_v) begin
                $display("%0t: sorted_key expected %h, got %h", $time, want.key_v, sorted_key);
                mismatches++;
            end
            if (sorted_payload !== want.pay_v) begin
                $display("%0t: sorted_payload expected %h, got %h",
                         $time, want.pay_v, sorted_payload);
                mismatches++;
            end
            if (last_result !== want.last_v) begin
                $display("%0t: last_result expected %b, got %b",
                         $time, want.last_v, last_result);
                mismatches++;
            end
            if (overflow !== want.ovf_v) begin
                $display("%0t: overflow expected %b, got %b", $time, want.ovf_v, overflow);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_count   = 0;
            held_dropped = 1'b0;
            order_mode   = '0;
            pending_sorted.delete();
        end
        else begin
            if (cfg_write_en)
                order_mode = cfg_write_data;
            if (in_valid && in_ready)
                take_element(key, payload, last_item);
            if (out_valid && out_ready)
                check_result();
        end
        awaiting = pending_sorted.size();
    end

endmodule

// ===== tb/sv/stable_insertion_sorter_tb.sv =====
module stable_insertion_sorter_tb
    import sis_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [MODE_W-1:0] {
        ORDER_UNSIGNED_ASC  = 2'd0,
        ORDER_SIGNED_ASC    = 2'd1,
        ORDER_UNSIGNED_DESC = 2'd2,
        ORDER_SIGNED_DESC   = 2'd3
    } order_mode_t;

    localparam int CLK_HALF     = 10;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 4000;
    // a full insertion walk plus margin
    localparam int SETTLE_CYCLES = 2 * DEPTH_DEF + 16;
    localparam int PHASE_ITEMS  = 14;

    localparam logic [KEY_WIDTH_DEF-1:0] KEY_ZERO    = 32'h0000_0000;
    localparam logic [KEY_WIDTH_DEF-1:0] KEY_ONES    = 32'hFFFF_FFFF;
    localparam logic [KEY_WIDTH_DEF-1:0] KEY_MOST_NEG = 32'h8000_0000;
    localparam logic [KEY_WIDTH_DEF-1:0] KEY_MOST_POS = 32'h7FFF_FFFF;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write_en = 1'b0;
    logic [MODE_W-1:0]            cfg_write_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [KEY_WIDTH_DEF-1:0]     key = '0;
    logic [PAYLOAD_WIDTH_DEF-1:0] payload = '0;
    logic                         last_item = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [KEY_WIDTH_DEF-1:0]     sorted_key;
    logic [PAYLOAD_WIDTH_DEF-1:0] sorted_payload;
    logic                         last_result;
    logic                         overflow;

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    bit          hold_off_req = 1'b0;
    int unsigned quiet_cycles = 0;

    always #CLK_HALF clk = ~clk;

    stable_insertion_sorter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key            (key),
        .payload        (payload),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .last_result    (last_result),
        .overflow       (overflow)
    );

    stable_insertion_sorter_checker sort_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key            (key),
        .payload        (payload),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .last_result    (last_result),
        .overflow       (overflow),
        .mismatches     (mismatches),
        .awaiting       (awaiting)
    );

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stable_insertion_sorter_tb: FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_elem(input logic [KEY_WIDTH_DEF-1:0] k,
                             input logic [PAYLOAD_WIDTH_DEF-1:0] p,
                             input logic is_last);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        key       = k;
        payload   = p;
        last_item = is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_WIDTH_DEF-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: begin
                case ($urandom_range(0, 3))
                    0: return KEY_ZERO;
                    1: return KEY_ONES;
                    2: return KEY_MOST_NEG;
                    default: return KEY_MOST_POS;
                endcase
            end
            default: return KEY_MOST_POS - 1 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic send_set(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_elem(pick_key(), PAYLOAD_WIDTH_DEF'($urandom_range(0, 65535)), i + 1 == n);
    endtask

    task automatic wait_drained(input int unsigned extra);
        while (awaiting != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_order(input order_mode_t m);
        cfg_write_en   = 1'b1;
        cfg_write_data = m;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic change_order(input order_mode_t m);
        in_valid = 1'b0;
        wait_drained(4);
        write_order(m);
    endtask

    int unsigned idle_of_phase  [4] = '{0, 51, 0, 15};
    int unsigned stall_of_phase [4] = '{0, 0, 51, 15};
    order_mode_t mode_of_phase  [4] = '{ORDER_SIGNED_DESC, ORDER_UNSIGNED_DESC,
                                        ORDER_SIGNED_ASC, ORDER_UNSIGNED_ASC};

    initial begin
        int unsigned sent;
        int unsigned n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_order(ORDER_UNSIGNED_ASC);

        // extremes and equal keys, unsigned ascending
        send_elem(KEY_ONES, 16'hFFFF, 1'b0);
        send_elem(KEY_ZERO, 16'h0000, 1'b0);
        send_elem(KEY_MOST_NEG, 16'h1234, 1'b0);
        send_elem(KEY_MOST_POS, 16'h8001, 1'b0);
        send_elem(32'd5, 16'hAAAA, 1'b0);
        send_elem(32'd5, 16'h5555, 1'b0);
        send_elem(KEY_ZERO, 16'h0001, 1'b1);
        // one-element set
        send_elem(32'h1234_5678, 16'hBEEF, 1'b1);

        change_order(ORDER_SIGNED_DESC);
        send_elem(KEY_MOST_NEG, 16'h0001, 1'b0);
        send_elem(KEY_MOST_POS, 16'h0002, 1'b0);
        send_elem(KEY_ONES, 16'h0003, 1'b0);
        send_elem(KEY_ZERO, 16'h0004, 1'b0);
        send_elem(KEY_ONES, 16'h0005, 1'b1);

        change_order(ORDER_UNSIGNED_DESC);
        send_elem(KEY_ZERO, 16'h0006, 1'b0);
        send_elem(KEY_ONES, 16'h0007, 1'b0);
        send_elem(32'd1, 16'h0008, 1'b0);
        send_elem(32'd1, 16'h0009, 1'b0);
        send_elem(KEY_ONES - 1, 16'h000A, 1'b1);

        // order switched part way through a set: no re-sort of held elements
        change_order(ORDER_SIGNED_ASC);
        send_elem(KEY_ONES, 16'h0010, 1'b0);
        send_elem(32'd1, 16'h0011, 1'b0);
        send_elem(KEY_MOST_NEG, 16'h0012, 1'b0);
        in_valid = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_order(ORDER_UNSIGNED_ASC);
        send_elem(KEY_MOST_POS, 16'h0013, 1'b0);
        send_elem(KEY_ONES - 1, 16'h0014, 1'b1);

        for (int p = 0; p < 4; p++) begin
            change_order(mode_of_phase[p]);
            in_idle_pct   = idle_of_phase[p];
            out_stall_pct = stall_of_phase[p];
            if (p == 0) begin
                // long receiver hold-off while the next set keeps being offered
                hold_off_req = 1'b1;
                send_set(12);
                send_set(6);
                // full store, the item marked last is itself dropped
                send_set(DEPTH_DEF + 1);
            end
            if (p == 2)
                send_set(DEPTH_DEF + 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                    change_order(order_mode_t'($urandom_range(0, 3)));
                send_set(n);
                sent += n;
            end
        end

        in_valid = 1'b0;
        wait_drained(SETTLE_CYCLES);
        if (mismatches == 0 && awaiting == 0)
            $display("stable_insertion_sorter_tb: PASS");
        else
            $display("stable_insertion_sorter_tb: FAIL");
        $finish;
    end

endmodule
